// File: sv/dotted_line_rasterizer_core_macros.svh
// Assertion macros used by the dotted line rasterizer checker.
`ifndef DOTTED_LINE_RASTERIZER_CORE_MACROS_SVH
`define DOTTED_LINE_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define DLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define DLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dlr_pkg.sv
// Shared constants of the dotted line rasterizer.
package dlr_pkg;

  // Default coordinate width in bits.
  localparam int unsigned COORD_WIDTH = 10;

  // Command codes carried on the cmd input.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

endpackage

// File: sv/dotted_line_rasterizer_core.sv
// Dotted line rasterizer: Bresenham stepper with a two-entry result buffer.
//
// The input channel carries one command per transaction. A start command
// (cmd = CMD_START) loads both endpoints and returns the first pixel of the
// line, always drawn. A step command (cmd = CMD_STEP) advances one pixel
// along the major axis; every other pixel is marked as not drawn, giving a
// one-on, one-off dotted pattern. done_res is set on the last pixel of a
// line, and a step while no line is active returns the last pixel again
// with drawn clear and done_res set.
//
// Each input transaction produces exactly one output transaction. The line
// state is updated in the cycle the command is accepted, and the result is
// registered in the output or skid entry. With out_ready_i held high a new
// command is accepted every cycle, so the throughput is one pixel per
// cycle; the rate is set by the single error add and compare per step.
//
// Results sit in an output register backed by a one-entry skid register.
// When the receiver stalls, one more command is still accepted; in_ready_o
// drops only once both entries are full. Reset clears the line state to
// idle with the current pixel at the origin and empties both entries.
module dotted_line_rasterizer_core #(
  parameter int unsigned CoordWidth = dlr_pkg::COORD_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [CoordWidth-1:0] start_x_i,
  input  logic [CoordWidth-1:0] start_y_i,
  input  logic [CoordWidth-1:0] end_x_i,
  input  logic [CoordWidth-1:0] end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CoordWidth-1:0] pixel_x_o,
  output logic [CoordWidth-1:0] pixel_y_o,
  output logic                  drawn_o,
  output logic                  done_res_o
);
  import dlr_pkg::*;

  // The error term needs three bits beyond a coordinate: twice a delta,
  // plus sign, plus headroom for the running sum.
  localparam int unsigned ErrWidth = CoordWidth + 3;
  localparam int unsigned AxWidth  = CoordWidth + 2;

  typedef struct packed {
    logic [CoordWidth-1:0] x;
    logic [CoordWidth-1:0] y;
    logic                  drawn;
    logic                  done;
  } result_t;

  // Line state.
  logic [CoordWidth-1:0]      cur_x_q, cur_x_d;
  logic [CoordWidth-1:0]      cur_y_q, cur_y_d;
  logic signed [ErrWidth-1:0] err_q, err_d;
  logic signed [ErrWidth-1:0] diag_q, diag_d;
  logic [AxWidth-1:0]         axial_q, axial_d;
  logic                       x_back_q, x_back_d;
  logic                       y_back_q, y_back_d;
  logic                       x_major_q, x_major_d;
  logic [CoordWidth-1:0]      steps_q, steps_d;
  logic                       odd_q, odd_d;
  logic                       busy_q, busy_d;

  // Result buffer.
  result_t out_q, out_d, skid_q, skid_d, res;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic in_fire;

  // Start setup.
  logic [CoordWidth:0]   dx, dy, ndx, ndy;
  logic [CoordWidth-1:0] adx, ady, major, minor;

  // Step datapath.
  logic                  minor_move;
  logic [CoordWidth-1:0] x_step, y_step, steps_dec;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    dx    = {1'b0, end_x_i} - {1'b0, start_x_i};
    dy    = {1'b0, end_y_i} - {1'b0, start_y_i};
    ndx   = -dx;
    ndy   = -dy;
    adx   = dx[CoordWidth] ? ndx[CoordWidth-1:0] : dx[CoordWidth-1:0];
    ady   = dy[CoordWidth] ? ndy[CoordWidth-1:0] : dy[CoordWidth-1:0];
    major = (adx > ady) ? adx : ady;
    minor = (adx > ady) ? ady : adx;

    minor_move = !err_q[ErrWidth-1];
    x_step     = x_back_q ? (cur_x_q - CoordWidth'(1)) : (cur_x_q + CoordWidth'(1));
    y_step     = y_back_q ? (cur_y_q - CoordWidth'(1)) : (cur_y_q + CoordWidth'(1));
    steps_dec  = steps_q - CoordWidth'(1);

    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    err_d     = err_q;
    diag_d    = diag_q;
    axial_d   = axial_q;
    x_back_d  = x_back_q;
    y_back_d  = y_back_q;
    x_major_d = x_major_q;
    steps_d   = steps_q;
    odd_d     = odd_q;
    busy_d    = busy_q;
    res       = '{x: cur_x_q, y: cur_y_q, drawn: 1'b0, done: 1'b1};

    if (cmd_i == CMD_START) begin
      x_back_d  = dx[CoordWidth];
      y_back_d  = dy[CoordWidth];
      x_major_d = adx > ady;
      err_d     = ErrWidth'({minor, 1'b0}) - ErrWidth'(major);
      diag_d    = ErrWidth'({minor, 1'b0}) - ErrWidth'({major, 1'b0});
      axial_d   = AxWidth'({minor, 1'b0});
      steps_d   = major;
      cur_x_d   = start_x_i;
      cur_y_d   = start_y_i;
      odd_d     = 1'b1;
      busy_d    = major != '0;
      res       = '{x: start_x_i, y: start_y_i, drawn: 1'b1, done: major == '0};
    end else if (busy_q) begin
      // Minor axis moves when the error term is non-negative; the major
      // axis moves on every step.
      if (minor_move) begin
        err_d = err_q + diag_q;
        if (x_major_q) begin
          cur_y_d = y_step;
        end else begin
          cur_x_d = x_step;
        end
      end else begin
        err_d = err_q + ErrWidth'(axial_q);
      end
      if (x_major_q) begin
        cur_x_d = x_step;
      end else begin
        cur_y_d = y_step;
      end
      odd_d   = !odd_q;
      steps_d = steps_dec;
      busy_d  = steps_dec != '0;
      res     = '{x: cur_x_d, y: cur_y_d, drawn: !odd_q, done: steps_dec == '0};
    end
  end

  // Output register with skid entry. The skid entry only fills when a
  // transaction is accepted while the output register is stalled.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      err_q        <= '0;
      diag_q       <= '0;
      axial_q      <= '0;
      x_back_q     <= 1'b0;
      y_back_q     <= 1'b0;
      x_major_q    <= 1'b0;
      steps_q      <= '0;
      odd_q        <= 1'b0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        cur_x_q   <= cur_x_d;
        cur_y_q   <= cur_y_d;
        err_q     <= err_d;
        diag_q    <= diag_d;
        axial_q   <= axial_d;
        x_back_q  <= x_back_d;
        y_back_q  <= y_back_d;
        x_major_q <= x_major_d;
        steps_q   <= steps_d;
        odd_q     <= odd_d;
        busy_q    <= busy_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = out_q.x;
  assign pixel_y_o   = out_q.y;
  assign drawn_o     = out_q.drawn;
  assign done_res_o  = out_q.done;

endmodule

// File: sv/dlr_checker.sv
// Port-level checker for the dotted line rasterizer, bound to the top level.
`include "dotted_line_rasterizer_core_macros.svh"

module dlr_checker #(
  parameter int unsigned CoordWidth = dlr_pkg::COORD_WIDTH
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [CoordWidth-1:0] pixel_x_o,
  input logic [CoordWidth-1:0] pixel_y_o,
  input logic                  drawn_o,
  input logic                  done_res_o
);

  // Transactions accepted at the input but not yet delivered at the output.
  logic [1:0] pend_q;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_fire && !out_fire) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `DLR_ASSERT_NOW(a_no_phantom_result, pend_q == 2'd0, !out_valid_o, "result with none pending")
  `DLR_ASSERT_NOW(a_full_blocks_input, pend_q == 2'd2, !in_ready_o, "input taken with buffer full")
  `DLR_ASSERT_NEXT(a_stalled_result_holds, out_valid_o && !out_ready_i,
    out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o) && $stable(drawn_o)
    && $stable(done_res_o), "stalled result changed")

endmodule

bind dotted_line_rasterizer_core dlr_checker #(.CoordWidth(CoordWidth)) u_dlr_checker (.*);
